### rtl/core/per_sender_cooldown_limiter_top_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the per-sender cooldown limiter
// Shorthand for clocked, reset-gated concurrent assertions.
// ---------------------------------------------------------------------------
`ifndef PER_SENDER_COOLDOWN_LIMITER_TOP_ASSERT_SVH
`define PER_SENDER_COOLDOWN_LIMITER_TOP_ASSERT_SVH

// Same-cycle implication
`define PSC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define PSC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/psc_pkg.sv
// ---------------------------------------------------------------------------
// psc_pkg
// Shared types and constants of the per-sender cooldown limiter.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package psc_pkg;

    localparam int unsigned ID_W   = 32;
    localparam int unsigned TIME_W = 32;
    localparam int unsigned CFG_W  = 32;
    localparam int unsigned CFG_ADDR_W = 1;

    localparam logic [CFG_ADDR_W-1:0] REG_DIRECT_COOLDOWN    = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_BROADCAST_COOLDOWN = 1'b1;

    localparam logic [CFG_W-1:0] DIRECT_COOLDOWN_RST    = 32'd15000;
    localparam logic [CFG_W-1:0] BROADCAST_COOLDOWN_RST = 32'd60000;

    // Request token walking down the slot chain
    typedef struct packed {
        logic              valid;
        logic [ID_W-1:0]   sender_id;
        logic [TIME_W-1:0] now_ms;
        logic [CFG_W-1:0]  cooldown;
        logic              found;
        logic              limited;
    } token_t;

    // Slot overwrite for a new sender
    typedef struct packed {
        logic              en;
        logic [ID_W-1:0]   sender_id;
        logic [TIME_W-1:0] now_ms;
    } slot_wr_t;

endpackage

`default_nettype wire

### rtl/core/psc_cell.sv
// ---------------------------------------------------------------------------
// psc_cell
// One table slot: holds a sender and its last reply time, checks the passing
// token against them and hands the token to the next slot.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module psc_cell
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire psc_pkg::token_t   tok_in,
    input  wire psc_pkg::slot_wr_t wr,
    output psc_pkg::token_t        tok_out
);

    logic [psc_pkg::ID_W-1:0]   sender_reg, sender_next;
    logic [psc_pkg::TIME_W-1:0] time_reg, time_next;
    psc_pkg::token_t            tok_reg, tok_next;

    logic                       hit;
    logic [psc_pkg::TIME_W-1:0] elapsed;
    logic                       too_soon;

    always_comb
    begin
        // first match only: a token already claimed passes through untouched
        hit      = tok_in.valid && !tok_in.found && (sender_reg == tok_in.sender_id);
        elapsed  = tok_in.now_ms - time_reg;
        too_soon = elapsed < tok_in.cooldown;

        tok_next    = tok_in;
        sender_next = sender_reg;
        time_next   = time_reg;

        if (hit)
        begin
            tok_next.found   = 1'b1;
            tok_next.limited = too_soon;
            if (!too_soon)
            begin
                time_next = tok_in.now_ms;
            end
        end

        if (wr.en)
        begin
            sender_next = wr.sender_id;
            time_next   = wr.now_ms;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sender_reg <= '0;
            time_reg   <= '0;
            tok_reg    <= '0;
        end
        else
        begin
            sender_reg <= sender_next;
            time_reg   <= time_next;
            tok_reg    <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

`default_nettype wire

### rtl/core/per_sender_cooldown_limiter_top.sv
// ---------------------------------------------------------------------------
// per_sender_cooldown_limiter_top
// Per-sender reply cooldown over a chain of slot cells with ring insertion.
// ---------------------------------------------------------------------------
//  channel   | direction | beat contents
//  s_axis    | in        | tdata: sender_id, now_ms; tuser: is_direct
//  m_axis    | out       | tdata: limited, inserted
//  cfg       | in        | write of direct / broadcast cooldown
//
// One request is in flight at a time. From accept to the next possible accept
// it passes the launch register, each slot cell in turn and the pending
// register, then retires into the output register.
// A stalled output beat holds retirement (and the next accept) back.
// Reset clears every slot to sender 0 at time 0 and the insert pointer.
`timescale 1ns / 1ps
`default_nettype none

module per_sender_cooldown_limiter_top
#(
    parameter int unsigned SLOTS = 8
)
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,

    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  wire logic [63:0]                       s_axis_tdata,  // [31:0] sender_id, [63:32] now_ms
    input  wire logic                              s_axis_tuser,  // [0] is_direct

    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    output logic [7:0]                             m_axis_tdata,  // [0] limited, [1] inserted, zero pad

    input  wire logic                              cfg_we,
    input  wire logic [psc_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  wire logic [psc_pkg::CFG_W-1:0]         cfg_wdata
);

    localparam int unsigned PTR_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    logic [psc_pkg::CFG_W-1:0] direct_cd_reg, direct_cd_next;
    logic [psc_pkg::CFG_W-1:0] bcast_cd_reg, bcast_cd_next;

    logic                      busy_reg, busy_next;
    logic [PTR_W-1:0]          ptr_reg, ptr_next;
    psc_pkg::token_t           head_reg, head_next;
    psc_pkg::token_t           pend_reg, pend_next;
    logic                      out_valid_reg, out_valid_next;
    logic                      out_limited_reg, out_limited_next;
    logic                      out_inserted_reg, out_inserted_next;

    psc_pkg::token_t           chain [SLOTS+1];
    psc_pkg::slot_wr_t         wr    [SLOTS];

    logic                      s_fire;
    logic                      retire;
    logic                      do_insert;

    assign s_axis_tready = !busy_reg;
    assign s_fire        = s_axis_tvalid && !busy_reg;
    assign retire        = pend_reg.valid && (!out_valid_reg || m_axis_tready);
    assign do_insert     = retire && !pend_reg.found;

    // configuration
    always_comb
    begin
        direct_cd_next = direct_cd_reg;
        bcast_cd_next  = bcast_cd_reg;
        if (cfg_we)
        begin
            unique case (cfg_addr)
                psc_pkg::REG_DIRECT_COOLDOWN:    direct_cd_next = cfg_wdata;
                psc_pkg::REG_BROADCAST_COOLDOWN: bcast_cd_next  = cfg_wdata;
                default:                         ;
            endcase
        end
    end

    // launch, settle and retire
    always_comb
    begin
        head_next           = '0;
        head_next.valid     = s_fire;
        head_next.sender_id = s_axis_tdata[31:0];
        head_next.now_ms    = s_axis_tdata[63:32];
        head_next.cooldown  = s_axis_tuser ? direct_cd_reg : bcast_cd_reg;

        busy_next         = busy_reg;
        ptr_next          = ptr_reg;
        pend_next         = pend_reg;
        out_valid_next    = out_valid_reg;
        out_limited_next  = out_limited_reg;
        out_inserted_next = out_inserted_reg;

        if (s_fire)
        begin
            busy_next = 1'b1;
        end

        if (m_axis_tvalid && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        // hold the finished token until the output register frees up
        if (chain[SLOTS].valid)
        begin
            pend_next = chain[SLOTS];
        end

        if (retire)
        begin
            pend_next.valid   = 1'b0;
            busy_next         = 1'b0;
            out_valid_next    = 1'b1;
            out_limited_next  = pend_reg.found && pend_reg.limited;
            out_inserted_next = !pend_reg.found;
            if (do_insert)
            begin
                if (ptr_reg == PTR_W'(SLOTS - 1))
                begin
                    ptr_next = '0;
                end
                else
                begin
                    ptr_next = ptr_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            direct_cd_reg    <= psc_pkg::DIRECT_COOLDOWN_RST;
            bcast_cd_reg     <= psc_pkg::BROADCAST_COOLDOWN_RST;
            busy_reg         <= 1'b0;
            ptr_reg          <= '0;
            head_reg         <= '0;
            pend_reg         <= '0;
            out_valid_reg    <= 1'b0;
            out_limited_reg  <= 1'b0;
            out_inserted_reg <= 1'b0;
        end
        else
        begin
            direct_cd_reg    <= direct_cd_next;
            bcast_cd_reg     <= bcast_cd_next;
            busy_reg         <= busy_next;
            ptr_reg          <= ptr_next;
            head_reg         <= head_next;
            pend_reg         <= pend_next;
            out_valid_reg    <= out_valid_next;
            out_limited_reg  <= out_limited_next;
            out_inserted_reg <= out_inserted_next;
        end
    end

    assign chain[0] = head_reg;

    for (genvar k = 0; k < SLOTS; k++)
    begin : g_slot
        always_comb
        begin
            wr[k].en        = do_insert && (ptr_reg == PTR_W'(k));
            wr[k].sender_id = pend_reg.sender_id;
            wr[k].now_ms    = pend_reg.now_ms;
        end

        psc_cell u_cell
        (
            .clk     (clk),
            .rst_n   (rst_n),
            .tok_in  (chain[k]),
            .wr      (wr[k]),
            .tok_out (chain[k+1])
        );
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'b0, out_inserted_reg, out_limited_reg};

endmodule

`default_nettype wire

### rtl/core/psc_chk.sv
// ---------------------------------------------------------------------------
// psc_chk
// Port-level checks of the per-sender cooldown limiter, bound to the top.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "per_sender_cooldown_limiter_top_assert.svh"

module psc_chk
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_axis_tvalid,
    input  wire logic       s_axis_tready,
    input  wire logic       m_axis_tvalid,
    input  wire logic       m_axis_tready,
    input  wire logic [7:0] m_axis_tdata
);

    // a stalled result beat stays put
    `PSC_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata), "result beat changed while stalled")

    // a limited request never claims a slot
    `PSC_ASSERT_SAME(a_lim_ins, m_axis_tvalid,
        !(m_axis_tdata[0] && m_axis_tdata[1]), "limited and inserted both set")

    // one request in flight: no accept in the cycle after an accept
    `PSC_ASSERT_NEXT(a_one_inflight, s_axis_tvalid && s_axis_tready,
        !s_axis_tready, "second request taken while one is in flight")

    `PSC_ASSERT_SAME(a_pad_zero, m_axis_tvalid,
        m_axis_tdata[7:2] == 6'b0, "result pad bits not zero")

endmodule

bind per_sender_cooldown_limiter_top psc_chk u_psc_chk (.*);

`default_nettype wire
